// ===== rtl/rlrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Region list run decoder package
// Shared types and byte-code constants for the region list run decoder.
// ----------------------------------------------------------------------------
package rlrd_pkg;

    localparam logic [7:0] C_SKIP_ESC  = 8'h3f;
    localparam logic [7:0] C_MARK_ESC  = 8'hff;
    localparam logic [7:0] C_MARK_SKIP = 8'h80;
    localparam logic [7:0] C_MARK_ONLY = 8'hc0;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_NONE,
        PH_LOW,
        PH_HIGH
    } t_phase;

    typedef struct packed {
        logic        restart;
        logic        emit;
        logic        trunc;
        logic [2:0]  pre;
        logic [15:0] mark;
        logic [15:0] adv;
    } t_cmd;

endpackage

// ===== rtl/rlrd_front.sv =====
// ----------------------------------------------------------------------------
// Region list run decoder front end
// Accepts bytes, tracks escape sequences and turns each byte into a command.
// ----------------------------------------------------------------------------
module rlrd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [7:0]           i_byte_value,
    input  logic                 i_list_start,
    input  logic                 i_list_end,
    input  logic                 i_full,
    output logic                 o_push,
    output rlrd_pkg::t_cmd       o_cmd
);

    rlrd_pkg::t_phase r_phase;
    rlrd_pkg::t_phase n_phase;
    rlrd_pkg::t_phase cur_phase;
    logic             r_is_mark;
    logic             n_is_mark;
    logic [7:0]       r_low;
    logic [7:0]       n_low;
    logic [15:0]      esc_val;
    logic             accept;

    assign accept = i_in_valid && !i_full;
    assign o_push = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= rlrd_pkg::PH_NONE;
            r_is_mark <= 1'b0;
            r_low     <= 8'h00;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_is_mark <= n_is_mark;
            r_low     <= n_low;
        end
    end

    always_comb begin
        cur_phase = i_list_start ? rlrd_pkg::PH_NONE : r_phase;
        n_phase   = rlrd_pkg::PH_NONE;
        n_is_mark = r_is_mark;
        n_low     = r_low;
        esc_val   = {i_byte_value, r_low};
        o_cmd         = '0;
        o_cmd.restart = i_list_start;
        unique case (cur_phase)
            rlrd_pkg::PH_LOW: begin
                n_low   = i_byte_value;
                n_phase = rlrd_pkg::PH_HIGH;
            end
            rlrd_pkg::PH_HIGH: begin
                o_cmd.adv = esc_val;
                if (r_is_mark) begin
                    o_cmd.mark = esc_val;
                    o_cmd.emit = (esc_val != 16'd0);
                end
            end
            default: begin
                priority if (i_byte_value < rlrd_pkg::C_SKIP_ESC) begin
                    o_cmd.adv = {8'h00, i_byte_value};
                end else if (i_byte_value == rlrd_pkg::C_SKIP_ESC
                             || i_byte_value == rlrd_pkg::C_MARK_ESC) begin
                    n_is_mark = (i_byte_value == rlrd_pkg::C_MARK_ESC);
                    n_phase   = rlrd_pkg::PH_LOW;
                end else if (i_byte_value < rlrd_pkg::C_MARK_SKIP) begin
                    o_cmd.pre  = i_byte_value[5:3];
                    o_cmd.mark = {13'd0, i_byte_value[2:0]};
                    o_cmd.emit = (i_byte_value[2:0] != 3'd0);
                    o_cmd.adv  = 16'(i_byte_value[5:3]) + 16'(i_byte_value[2:0]);
                end else if (i_byte_value < rlrd_pkg::C_MARK_ONLY) begin
                    o_cmd.mark = {13'd0, i_byte_value[5:3]};
                    o_cmd.emit = (i_byte_value[5:3] != 3'd0);
                    o_cmd.adv  = 16'(i_byte_value[5:3]) + 16'(i_byte_value[2:0]);
                end else begin
                    o_cmd.mark = {10'd0, i_byte_value[5:0]};
                    o_cmd.emit = (i_byte_value[5:0] != 6'd0);
                    o_cmd.adv  = {10'd0, i_byte_value[5:0]};
                end
            end
        endcase
        if (i_list_end && n_phase != rlrd_pkg::PH_NONE) begin
            n_phase     = rlrd_pkg::PH_NONE;
            o_cmd.trunc = 1'b1;
        end
    end

endmodule

// ===== rtl/rlrd_queue.sv =====
// ----------------------------------------------------------------------------
// Region list run decoder command queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rlrd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rlrd_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output rlrd_pkg::t_cmd       o_cmd
);

    rlrd_pkg::t_cmd                      r_mem [rlrd_pkg::QUEUE_DEPTH];
    logic [rlrd_pkg::QUEUE_AW-1:0]       r_wr;
    logic [rlrd_pkg::QUEUE_AW-1:0]       r_rd;
    logic [rlrd_pkg::QUEUE_CW-1:0]       r_cnt;

    assign o_full  = (r_cnt == rlrd_pkg::QUEUE_CW'(rlrd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == rlrd_pkg::QUEUE_AW'(rlrd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == rlrd_pkg::QUEUE_AW'(rlrd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/rlrd_back.sv =====
// ----------------------------------------------------------------------------
// Region list run decoder back end
// Applies commands to the running region ID and registers the emitted runs.
// ----------------------------------------------------------------------------
module rlrd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  rlrd_pkg::t_cmd       i_cmd,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [15:0]          o_run_start,
    output logic [15:0]          o_run_count,
    output logic                 o_truncated
);

    logic [15:0] r_id;
    logic [15:0] id_base;
    logic        r_valid;
    logic [15:0] r_start;
    logic [15:0] r_count;
    logic        r_trunc;
    logic        load_ok;
    logic        has_out;
    logic        emit_now;

    assign id_base  = i_cmd.restart ? 16'd1 : r_id;
    assign load_ok  = !r_valid || !i_out_stall;
    assign has_out  = i_cmd.emit || i_cmd.trunc;
    assign o_pop    = i_cmd_valid && (load_ok || !has_out);
    assign emit_now = o_pop && has_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id    <= 16'd1;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_id <= id_base + i_cmd.adv;
            end
            if (load_ok) begin
                r_valid <= emit_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_now) begin
            r_start <= i_cmd.trunc ? 16'd0 : id_base + 16'(i_cmd.pre);
            r_count <= i_cmd.trunc ? 16'd0 : i_cmd.mark;
            r_trunc <= i_cmd.trunc;
        end
    end

    assign o_out_valid = r_valid;
    assign o_run_start = r_start;
    assign o_run_count = r_count;
    assign o_truncated = r_trunc;

endmodule

// ===== rtl/region_list_run_decoder.sv =====
// ----------------------------------------------------------------------------
// Region list run decoder
// Decodes a byte-coded sparse list of region IDs into runs of start and count.
// ----------------------------------------------------------------------------
// The input channel takes one coded byte per word with its list start and
// list end flags; the block holds o_in_stall high while its command queue is
// full. The output channel gives one word per marked run, or one word with
// o_truncated set when a list ends inside a three-byte escape.
// An accepted byte is written into the command queue, and the back end
// registers the run of the command at the queue head in the output word. The
// block accepts one byte per cycle while its queue is not full and emits at
// most one run per byte. Skip codes produce no word; escape bytes give one only
// for a nonzero mark escape or when a list ends inside the escape.
// A synchronous reset empties the queue, drops the output word, clears any
// pending escape and sets the running ID to one; no clearing pass follows.
// When the receiver stalls, the output word holds; bytes that produce no run
// still drain from the queue, and the input stalls once the two-entry queue
// fills.
// ----------------------------------------------------------------------------
module region_list_run_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_list_start,
    input  logic        i_list_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_run_start,
    output logic [15:0] o_run_count,
    output logic        o_truncated
);

    rlrd_pkg::t_cmd push_cmd;
    rlrd_pkg::t_cmd head_cmd;
    logic           push;
    logic           pop;
    logic           full;
    logic           head_valid;

    assign o_in_stall = full;

    rlrd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_byte_value (i_byte_value),
        .i_list_start (i_list_start),
        .i_list_end   (i_list_end),
        .i_full       (full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    rlrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    rlrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_run_start (o_run_start),
        .o_run_count (o_run_count),
        .o_truncated (o_truncated)
    );

endmodule

// ===== rtl/rlrd_checker.sv =====
// ----------------------------------------------------------------------------
// Region list run decoder checker
// Port-level assertions on the region list run decoder, attached by bind.
// ----------------------------------------------------------------------------
module rlrd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_in_stall,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] o_run_start,
    input  logic [15:0] o_run_count,
    input  logic        o_truncated
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("Reset did not clear the output or the input stall.");

    a_trunc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_truncated |-> o_run_start == 16'd0 && o_run_count == 16'd0)
        else $error("A truncated word carries a nonzero run.");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_truncated |-> o_run_count != 16'd0)
        else $error("An empty run was emitted.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_run_start)
            && $stable(o_run_count) && $stable(o_truncated))
        else $error("A stalled output word changed.");

endmodule

bind region_list_run_decoder rlrd_checker u_rlrd_checker (.*);

// ===== verif/region_list_run_decoder_chk.sv =====
// ----------------------------------------------------------------------------
// Region list run decoder checker
// Watches both channels of the decoder and keeps its own copy of the running
// ID and escape state. Every accepted byte is decoded into the run it should
// produce. Every accepted output word is compared field by field with the
// oldest run still owed.
// ----------------------------------------------------------------------------
module region_list_run_decoder_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_list_start,
    input  logic        i_list_end,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_run_start,
    input  logic [15:0] i_run_count,
    input  logic        i_truncated,
    output int          o_fail_count,
    output int          o_runs_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] count;
        logic        trunc;
    } t_run;

    t_run             runs_owed[$];
    logic [31:0]      cur_id;
    rlrd_pkg::t_phase esc_phase;
    logic             esc_mark;
    logic [7:0]       esc_low;
    t_run             next_run;
    logic             next_hit;
    int               fails = 0;

    assign o_fail_count = fails;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("ERROR at %0t ns: %s: got %h, expected %h", $time, what, got, want);
        fails++;
    endtask

    function automatic void open_run(input logic [15:0] len);
        if (len != 16'd0) begin
            next_run = '{start: cur_id[15:0], count: len, trunc: 1'b0};
            next_hit = 1'b1;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic is_first,
                                        input logic is_last);
        logic [15:0] len;
        logic [2:0]  mk;
        logic [2:0]  sk;
        next_hit = 1'b0;
        next_run = '0;
        if (is_first) begin
            cur_id    = 32'd1;
            esc_phase = rlrd_pkg::PH_NONE;
        end
        case (esc_phase)
            rlrd_pkg::PH_LOW: begin
                esc_low   = b;
                esc_phase = rlrd_pkg::PH_HIGH;
            end
            rlrd_pkg::PH_HIGH: begin
                len = {b, esc_low};
                if (esc_mark) begin
                    open_run(len);
                end
                cur_id    = cur_id + len;
                esc_phase = rlrd_pkg::PH_NONE;
            end
            default: begin
                esc_phase = rlrd_pkg::PH_NONE;
                if (b < rlrd_pkg::C_SKIP_ESC) begin
                    cur_id = cur_id + b;
                end else if (b == rlrd_pkg::C_SKIP_ESC || b == rlrd_pkg::C_MARK_ESC) begin
                    esc_mark  = (b == rlrd_pkg::C_MARK_ESC);
                    esc_phase = rlrd_pkg::PH_LOW;
                end else if (b < rlrd_pkg::C_MARK_SKIP) begin
                    sk     = b[5:3];
                    mk     = b[2:0];
                    cur_id = cur_id + sk;
                    open_run(16'(mk));
                    cur_id = cur_id + mk;
                end else if (b < rlrd_pkg::C_MARK_ONLY) begin
                    mk = b[5:3];
                    sk = b[2:0];
                    open_run(16'(mk));
                    cur_id = cur_id + mk;
                    cur_id = cur_id + sk;
                end else begin
                    len = 16'(b - rlrd_pkg::C_MARK_ONLY);
                    open_run(len);
                    cur_id = cur_id + len;
                end
            end
        endcase
        if (is_last && esc_phase != rlrd_pkg::PH_NONE) begin
            esc_phase = rlrd_pkg::PH_NONE;
            next_run  = '{start: 16'd0, count: 16'd0, trunc: 1'b1};
            next_hit  = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_run want;
        if (!i_rst_n) begin
            cur_id    = 32'd1;
            esc_phase = rlrd_pkg::PH_NONE;
            esc_mark  = 1'b0;
            esc_low   = 8'd0;
            runs_owed.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (runs_owed.size() == 0) begin
                    report_mismatch("word with no run owed, run_start", i_run_start, 16'hxxxx);
                end else begin
                    want = runs_owed.pop_front();
                    if (i_run_start !== want.start) begin
                        report_mismatch("run_start", i_run_start, want.start);
                    end
                    if (i_run_count !== want.count) begin
                        report_mismatch("run_count", i_run_count, want.count);
                    end
                    if (i_truncated !== want.trunc) begin
                        report_mismatch("truncated", 16'(i_truncated), 16'(want.trunc));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                decode_byte(i_byte_value, i_list_start, i_list_end);
                if (next_hit) begin
                    runs_owed.push_back(next_run);
                end
            end
        end
        o_runs_owed <= runs_owed.size();
    end

endmodule

// ===== verif/region_list_run_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// Region list run decoder testbench
// Feeds the decoder a directed set of byte codes covering every code class,
// escape lengths at their extremes, empty runs and lists that end inside an
// escape, then about a thousand bytes of random lists with random gaps on the
// input side and random stalls on the output side. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module region_list_run_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 1000;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [7:0]  i_byte_value = 8'd0;
    logic        i_list_start = 1'b0;
    logic        i_list_end   = 1'b0;
    logic        i_out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_run_start;
    logic [15:0] o_run_count;
    logic        o_truncated;
    int          fail_count;
    int          runs_owed;

    bit          in_gaps    = 1'b1;
    bit          out_calm   = 1'b0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          bytes_sent  = 0;

    always #1 i_clk = ~i_clk;

    region_list_run_decoder uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_byte_value (i_byte_value),
        .i_list_start (i_list_start),
        .i_list_end   (i_list_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_run_start  (o_run_start),
        .o_run_count  (o_run_count),
        .o_truncated  (o_truncated)
    );

    region_list_run_decoder_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_byte_value (i_byte_value),
        .i_list_start (i_list_start),
        .i_list_end   (i_list_end),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_run_start  (o_run_start),
        .i_run_count  (o_run_count),
        .i_truncated  (o_truncated),
        .o_fail_count (fail_count),
        .o_runs_owed  (runs_owed)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            if ($urandom_range(0, 39) == 0) begin
                out_calm = !out_calm;
            end
            stall_left = out_calm ? 0 : gap_len();
            i_out_stall <= 1'b0;
        end else begin
            stall_left--;
            i_out_stall <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("region_list_run_decoder test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        int g;
        g = in_gaps ? gap_len() : 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_byte_value <= b;
        i_list_start <= first;
        i_list_end   <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] high_len_byte();
        return ($urandom_range(0, 9) < 7) ? 8'd0 : 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_list();
        logic [7:0] codes[$];
        int         tokens;
        int         r;
        int         cut;
        tokens = $urandom_range(1, 8);
        if ($urandom_range(0, 99) < 8) begin
            repeat (tokens) begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
        end else begin
            repeat (tokens) begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    codes.push_back(8'($urandom_range(0, 62)));
                end else if (r < 45) begin
                    codes.push_back(8'($urandom_range(64, 127)));
                end else if (r < 65) begin
                    codes.push_back(8'($urandom_range(128, 191)));
                end else if (r < 80) begin
                    codes.push_back(8'($urandom_range(192, 254)));
                end else begin
                    codes.push_back((r < 90) ? rlrd_pkg::C_MARK_ESC : rlrd_pkg::C_SKIP_ESC);
                    codes.push_back(8'($urandom_range(0, 255)));
                    codes.push_back(high_len_byte());
                end
            end
            if (codes.size() > 1 && $urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, codes.size() - 1);
                repeat (cut) void'(codes.pop_back());
            end
            foreach (codes[i]) begin
                send_byte(codes[i], i == 0, i == codes.size() - 1);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h3e, 1'b0, 1'b0);
        send_byte(8'h47, 1'b0, 1'b0);
        send_byte(8'h7f, 1'b0, 1'b0);
        send_byte(8'hbf, 1'b0, 1'b0);
        send_byte(rlrd_pkg::C_MARK_SKIP, 1'b0, 1'b0);
        send_byte(rlrd_pkg::C_MARK_ONLY, 1'b0, 1'b0);
        send_byte(8'hfe, 1'b0, 1'b0);
        send_byte(rlrd_pkg::C_SKIP_ESC, 1'b0, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(rlrd_pkg::C_MARK_ESC, 1'b0, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(rlrd_pkg::C_MARK_ESC, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hc1, 1'b0, 1'b1);
        send_byte(8'hc3, 1'b0, 1'b0);
        send_byte(rlrd_pkg::C_MARK_ESC, 1'b0, 1'b1);
        send_byte(rlrd_pkg::C_SKIP_ESC, 1'b1, 1'b0);
        send_byte(8'h12, 1'b0, 1'b1);
        send_byte(rlrd_pkg::C_MARK_ESC, 1'b1, 1'b0);
        send_byte(8'h05, 1'b0, 1'b0);
        send_byte(8'h89, 1'b1, 1'b1);

        while (bytes_sent < 1000) begin
            in_gaps = ($urandom_range(0, 4) != 0);
            send_random_list();
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (runs_owed != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && runs_owed == 0) begin
            $display("region_list_run_decoder test passed");
        end else begin
            $display("region_list_run_decoder test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rlrd_pkg.sv
rtl/rlrd_front.sv
rtl/rlrd_queue.sv
rtl/rlrd_back.sv
rtl/region_list_run_decoder.sv
rtl/rlrd_checker.sv
verif/region_list_run_decoder_chk.sv
verif/region_list_run_decoder_tb.sv
